// ===== rtl/core/uncompressed_gif_image_stream_encoder_assert.svh =====
// Assertion macros used by the encoder RTL.
`ifndef UNCOMPRESSED_GIF_IMAGE_STREAM_ENCODER_ASSERT_SVH
`define UNCOMPRESSED_GIF_IMAGE_STREAM_ENCODER_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define GIFENC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked in and out of reset.
`define GIFENC_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/gifenc_pkg.sv =====
package gifenc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_GAIN         = 2'd2;
  localparam logic [1:0] CFG_INVERT_MODE  = 2'd3;

  localparam logic [15:0] GAIN_RESET = 16'd31744;

  localparam logic [7:0] BYTE_SEPARATOR = 8'h2C;
  localparam logic [7:0] BYTE_MIN_CODE  = 8'h07;
  localparam logic [7:0] BYTE_CLEAR     = 8'h80;
  localparam logic [7:0] BYTE_ONE       = 8'h01;
  localparam logic [7:0] BYTE_STOP      = 8'h81;
  localparam logic [7:0] BYTE_ZERO      = 8'h00;
  localparam logic [6:0] CODE_MAX       = 7'd127;

  // Byte positions of the output sequence caused by one pixel.
  typedef enum logic [4:0] {
    SLOT_SEP      = 5'd0,
    SLOT_LEFT_LO  = 5'd1,
    SLOT_LEFT_HI  = 5'd2,
    SLOT_TOP_LO   = 5'd3,
    SLOT_TOP_HI   = 5'd4,
    SLOT_W_LO     = 5'd5,
    SLOT_W_HI     = 5'd6,
    SLOT_H_LO     = 5'd7,
    SLOT_H_HI     = 5'd8,
    SLOT_FLAGS    = 5'd9,
    SLOT_MIN_CODE = 5'd10,
    SLOT_LEN      = 5'd11,
    SLOT_CLEAR    = 5'd12,
    SLOT_PIX      = 5'd13,
    SLOT_BLK      = 5'd14,
    SLOT_STOP     = 5'd15,
    SLOT_END      = 5'd16
  } slot_t;

  // One accepted pixel with the framing it needs.
  typedef struct packed {
    logic        desc;
    logic        hdr;
    logic [6:0]  len_byte;
    logic        trailer;
    logic [15:0] sample;
  } item_t;

endpackage

// ===== rtl/core/uncompressed_gif_image_stream_encoder.sv =====
// Each accepted sample waits in a hold register; its bytes then leave one at a time
// through the byte output register, which loads only when it is free. Throughput: one
// sample per cycle inside a chunk while out_tready allows; a chunk start adds 2 bytes,
// an image start 11 more and the image end 3 more, all paced by the byte output register.
// Reset (synchronous, active low) clears counters, the descriptor flag and both valid
// stages, and loads width 1, height 1, gain 124.0 and normal polarity.
`include "uncompressed_gif_image_stream_encoder_assert.svh"
module uncompressed_gif_image_stream_encoder
  import gifenc_pkg::*;
#(
  parameter int CHUNK_PIXELS = 120
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] data_byte
  output logic        out_tuser,  // [0] image_done
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] image_width_r, image_height_r, gain_r;
  logic        invert_mode_r;
  item_t       item;
  logic        in_accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= 16'd1;
      image_height_r <= 16'd1;
      gain_r         <= GAIN_RESET;
      invert_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
        CFG_GAIN:         gain_r         <= cfg_wdata;
        CFG_INVERT_MODE:  invert_mode_r  <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  assign in_accept = in_tvalid && in_tready;

  gifenc_ctrl #(
    .CHUNK_PIXELS(CHUNK_PIXELS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .sample       (in_tdata),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .item         (item)
  );

  gifenc_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_item      (item),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .gain         (gain_r),
    .invert_mode  (invert_mode_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_byte     (out_tdata),
    .out_done     (out_tuser)
  );

  `GIFENC_ASSERT_NOW(a_done_on_zero, clk, rst_n,
    out_tvalid && out_tuser, out_tdata == BYTE_ZERO, "image_done on a nonzero byte")
  `GIFENC_ASSERT_NOW(a_chunk_len, clk, rst_n, in_accept && item.hdr,
    (item.len_byte >= 7'd2) && (item.len_byte <= 7'(CHUNK_PIXELS + 1)),
    "chunk length byte out of range")
  `GIFENC_ASSERT_NEXT(a_reset_idle, clk, !rst_n, !out_tvalid, "output valid after reset")

endmodule

// ===== rtl/core/gifenc_ctrl.sv =====
module gifenc_ctrl
  import gifenc_pkg::*;
#(
  parameter int CHUNK_PIXELS = 120
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [15:0] sample,
  input  logic [15:0] image_width,
  input  logic [15:0] image_height,
  output item_t       item
);

  logic [15:0] column_r, column_nxt;
  logic [15:0] row_r, row_nxt;
  logic [6:0]  chunk_r, chunk_nxt;
  logic        desc_sent_r, desc_sent_nxt;

  logic [15:0] w, h, rem, col_inc, row_inc;
  logic [6:0]  len, chunk_inc;
  logic        row_end, frame_end;

  always_comb begin
    w         = (image_width == 16'd0) ? 16'd1 : image_width;
    h         = (image_height == 16'd0) ? 16'd1 : image_height;
    rem       = (column_r < w) ? (w - column_r) : 16'd1;
    len       = (rem < 16'(CHUNK_PIXELS)) ? rem[6:0] : 7'(CHUNK_PIXELS);
    col_inc   = column_r + 16'd1;
    row_inc   = row_r + 16'd1;
    chunk_inc = chunk_r + 7'd1;
    row_end   = (col_inc >= w) || (col_inc == 16'd0);
    frame_end = row_end && ((row_inc >= h) || (row_inc == 16'd0));

    item.desc     = !desc_sent_r;
    item.hdr      = (chunk_r == 7'd0);
    item.len_byte = len + 7'd1;
    item.trailer  = frame_end;
    item.sample   = sample;

    chunk_nxt     = (chunk_inc >= 7'(CHUNK_PIXELS)) ? 7'd0 : chunk_inc;
    column_nxt    = col_inc;
    row_nxt       = row_r;
    desc_sent_nxt = !frame_end;
    if (row_end) begin
      column_nxt = 16'd0;
      chunk_nxt  = 7'd0;
      row_nxt    = frame_end ? 16'd0 : row_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r    <= '0;
      row_r       <= '0;
      chunk_r     <= '0;
      desc_sent_r <= 1'b0;
    end else if (accept) begin
      column_r    <= column_nxt;
      row_r       <= row_nxt;
      chunk_r     <= chunk_nxt;
      desc_sent_r <= desc_sent_nxt;
    end
  end

endmodule

// ===== rtl/core/gifenc_emit.sv =====
module gifenc_emit
  import gifenc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  input  logic [15:0] image_width,
  input  logic [15:0] image_height,
  input  logic [15:0] gain,
  input  logic        invert_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_done
);

  logic        hold_valid_r;
  item_t       item_r;
  slot_t       slot_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_done_r;

  logic        out_load, last_slot, hold_done, accept;
  logic [4:0]  slot_inc;
  slot_t       slot_next, slot_start;
  logic [31:0] prod;
  logic [32:0] rounded;
  logic [8:0]  code_full;
  logic [6:0]  code_sat, code;
  logic [7:0]  byte_val;

  always_comb begin
    out_load  = !out_valid_r || out_ready;
    last_slot = (slot_r == (item_r.trailer ? SLOT_END : SLOT_PIX));
    hold_done = hold_valid_r && out_load && last_slot;
    in_ready  = !hold_valid_r || hold_done;
    accept    = in_valid && in_ready;

    slot_start = in_item.desc ? SLOT_SEP : (in_item.hdr ? SLOT_LEN : SLOT_PIX);
    slot_inc   = slot_r + 5'd1;
    if (slot_r == SLOT_MIN_CODE) begin
      slot_next = item_r.hdr ? SLOT_LEN : SLOT_PIX;
    end else begin
      slot_next = slot_t'(slot_inc);
    end

    // Q0.16 sample times Q8.8 gain, rounded to the nearest code.
    prod      = item_r.sample * gain;
    rounded   = {1'b0, prod} + 33'h0_0080_0000;
    code_full = rounded[32:24];
    code_sat  = (code_full > 9'(CODE_MAX)) ? CODE_MAX : code_full[6:0];
    code      = invert_mode ? (CODE_MAX - code_sat) : code_sat;

    unique case (slot_r)
      SLOT_SEP:      byte_val = BYTE_SEPARATOR;
      SLOT_W_LO:     byte_val = image_width[7:0];
      SLOT_W_HI:     byte_val = image_width[15:8];
      SLOT_H_LO:     byte_val = image_height[7:0];
      SLOT_H_HI:     byte_val = image_height[15:8];
      SLOT_MIN_CODE: byte_val = BYTE_MIN_CODE;
      SLOT_LEN:      byte_val = {1'b0, item_r.len_byte};
      SLOT_CLEAR:    byte_val = BYTE_CLEAR;
      SLOT_PIX:      byte_val = {1'b0, code};
      SLOT_BLK:      byte_val = BYTE_ONE;
      SLOT_STOP:     byte_val = BYTE_STOP;
      default:       byte_val = BYTE_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      slot_r       <= SLOT_SEP;
    end else if (accept) begin
      hold_valid_r <= 1'b1;
      slot_r       <= slot_start;
    end else if (hold_done) begin
      hold_valid_r <= 1'b0;
    end else if (hold_valid_r && out_load) begin
      slot_r <= slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= hold_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= byte_val;
      out_done_r <= (slot_r == SLOT_END);
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_done  = out_done_r;

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gifenc_pkg::*;

  localparam int CHUNK_PIXELS   = 120;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int RANDOM_ITEMS   = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       done;
  } gif_byte_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;  // [7:0] data_byte
  logic        out_tuser;  // [0] image_done
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  uncompressed_gif_image_stream_encoder #(
    .CHUNK_PIXELS(CHUNK_PIXELS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Mirror of the encoder registers and counters.
  logic [15:0] cur_width  = 16'd1;
  logic [15:0] cur_height = 16'd1;
  logic [15:0] cur_gain   = GAIN_RESET;
  logic        cur_invert = 1'b0;
  logic [15:0] col_count  = '0;
  logic [15:0] row_count  = '0;
  logic [6:0]  chunk_pos  = '0;
  logic        desc_sent  = 1'b0;

  gif_byte_t pending_bytes[$];
  int        err_count = 0;
  int        burst_left = 0;
  bit        steady_sender = 1'b0;

  bit        hold_req = 1'b0;
  bit        hold_done = 1'b0;
  int        hold_cnt = 0;
  rx_mode_t  rx_mode = RX_OPEN;
  int        rx_left = 0;
  int        rx_phase = 0;
  int        idle_cycles = 0;

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  function automatic void push_byte(input logic [7:0] b, input logic d);
    gif_byte_t e;
    e.data = b;
    e.done = d;
    pending_bytes.push_back(e);
  endfunction

  function automatic logic [7:0] pixel_code(input logic [15:0] s);
    logic [32:0] prod;
    logic [8:0]  code;
    prod = 33'(s) * 33'(cur_gain) + 33'h0080_0000;
    code = prod[32:24];
    if (code > 9'(CODE_MAX)) code = 9'(CODE_MAX);
    if (cur_invert) code = 9'(CODE_MAX) - code;
    return code[7:0];
  endfunction

  // Appends every byte that one accepted sample produces.
  function automatic void encode_sample(input logic [15:0] s);
    int unsigned w, h, rem, len;
    w = (cur_width == 0) ? 1 : cur_width;
    h = (cur_height == 0) ? 1 : cur_height;
    if (!desc_sent) begin
      push_byte(BYTE_SEPARATOR, 1'b0);
      repeat (4) push_byte(BYTE_ZERO, 1'b0);
      push_byte(cur_width[7:0], 1'b0);
      push_byte(cur_width[15:8], 1'b0);
      push_byte(cur_height[7:0], 1'b0);
      push_byte(cur_height[15:8], 1'b0);
      push_byte(BYTE_ZERO, 1'b0);
      push_byte(BYTE_MIN_CODE, 1'b0);
      desc_sent = 1'b1;
    end
    if (chunk_pos == 0) begin
      // A column count already past a shrunk width announces one pixel.
      rem = (col_count < w) ? (w - col_count) : 1;
      len = (rem < CHUNK_PIXELS) ? rem : CHUNK_PIXELS;
      push_byte(8'(len + 1), 1'b0);
      push_byte(BYTE_CLEAR, 1'b0);
    end
    push_byte(pixel_code(s), 1'b0);
    chunk_pos = chunk_pos + 7'd1;
    if (chunk_pos >= CHUNK_PIXELS) chunk_pos = '0;
    col_count = col_count + 16'd1;
    if (col_count >= w || col_count == 0) begin
      col_count = '0;
      chunk_pos = '0;
      row_count = row_count + 16'd1;
      if (row_count >= h || row_count == 0) begin
        row_count = '0;
        desc_sent = 1'b0;
        push_byte(BYTE_ONE, 1'b0);
        push_byte(BYTE_STOP, 1'b0);
        push_byte(BYTE_ZERO, 1'b1);
      end
    end
  endfunction

  // Offers one sample, waits for its word to be taken, then maybe idles.
  task automatic send_sample(input logic [15:0] s);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    encode_sample(s);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = steady_sender ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] w, input logic [15:0] h,
                            input logic [15:0] g, input logic inv);
    wait_results_done();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_addr  <= CFG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_addr  <= CFG_GAIN;
    cfg_wdata <= g;
    @(negedge clk);
    cfg_addr  <= CFG_INVERT_MODE;
    cfg_wdata <= {15'd0, inv};
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_width  = w;
    cur_height = h;
    cur_gain   = g;
    cur_invert = inv;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Reset values: one-pixel images, gain 124.0, so every sample is a full image.
  task automatic test_reset_defaults();
    send_sample(16'h0000);
    send_sample(16'hFFFF);
  endtask

  // Gain 1.0 puts the rounding threshold exactly at half scale.
  task automatic test_rounding();
    set_config(16'd4, 16'd1, 16'd256, 1'b0);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
  endtask

  // Zero width and height count as one but go into the descriptor as zero.
  task automatic test_zero_size_invert();
    set_config(16'd0, 16'd0, 16'hFFFF, 1'b1);
    send_sample(16'h8000);
    send_sample(16'h0001);
    send_sample(16'h0000);
  endtask

  task automatic test_gain_zero();
    set_config(16'd3, 16'd2, 16'd0, 1'b1);
    repeat (6) send_sample(rand_sample());
  endtask

  // One full chunk at the largest size, then the width shrinks under the count.
  task automatic test_shrink_mid_image();
    set_config(16'hFFFF, 16'hFFFF, GAIN_RESET, 1'b0);
    repeat (CHUNK_PIXELS) send_sample(rand_sample());
    set_config(16'd50, 16'd1, GAIN_RESET, 1'b0);
    send_sample(rand_sample());
  endtask

  task automatic test_pause_mid_image();
    set_config(16'd7, 16'd3, 16'h2000, 1'b0);
    repeat (9) send_sample(rand_sample());
    wait_results_done();
    repeat (12) send_sample(rand_sample());
  endtask

  task automatic test_backpressure();
    set_config(16'd10, 16'd4, 16'h6000, 1'b1);
    steady_sender = 1'b1;
    hold_req = 1'b1;
    repeat (80) send_sample(rand_sample());
    steady_sender = 1'b0;
    wait (hold_done);
    hold_req = 1'b0;
  endtask

  task automatic test_random_images();
    int sent, pick, images, n;
    int unsigned wh;
    logic [15:0] w, h, g;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) w = 16'($urandom_range(1, 12));
      else if (pick < 17) w = 16'($urandom_range(118, 122));
      else if (pick < 19) w = 16'($urandom_range(239, 241));
      else w = 16'd0;
      if ($urandom_range(0, 9) == 0) h = 16'd0;
      else if (w > 200) h = 16'd1;
      else if (w > 100) h = 16'($urandom_range(1, 2));
      else h = 16'($urandom_range(1, 4));
      case ($urandom_range(0, 7))
        0: g = 16'd0;
        1: g = 16'hFFFF;
        2: g = 16'd256;
        3, 4: g = 16'($urandom_range(0, 32767));
        default: g = 16'($urandom_range(0, 65535));
      endcase
      set_config(w, h, g, 1'($urandom_range(0, 1)));
      steady_sender = ($urandom_range(0, 3) == 0);
      wh = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      images = (w > 100) ? 1 : $urandom_range(1, 3);
      // Some phases stop mid-image so the next sizes land on live counters.
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, wh);
      else n = images * wh;
      repeat (n) send_sample(rand_sample());
      sent += n;
    end
    steady_sender = 1'b0;
  endtask

  // Receiver: random stall patterns, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
    end else begin
      if (!hold_req) begin
        hold_done = 1'b0;
        hold_cnt = 0;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 300);
      end else begin
        rx_left--;
      end
      rx_phase++;
      case (rx_mode)
        RX_OPEN:     out_tready <= 1'b1;
        RX_COIN:     out_tready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: out_tready <= ((rx_phase % 4) != 3);
        default:     out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Compares each output word with the oldest predicted byte.
  always @(posedge clk) begin
    gif_byte_t exp_b;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bytes.size() == 0) begin
        note_error($sformatf("unexpected byte %02h image_done %0b", out_tdata, out_tuser));
      end else begin
        exp_b = pending_bytes.pop_front();
        if (out_tdata !== exp_b.data || out_tuser !== exp_b.done)
          note_error($sformatf("byte mismatch: expected %02h done %0b, got %02h done %0b",
                               exp_b.data, exp_b.done, out_tdata, out_tuser));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_rounding();
    test_zero_size_invert();
    test_gain_zero();
    test_shrink_mid_image();
    test_pause_mid_image();
    test_backpressure();
    test_random_images();
    wait_results_done();
    repeat (10) @(posedge clk);
    if (err_count == 0 && pending_bytes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/gifenc_pkg.sv
rtl/core/gifenc_ctrl.sv
rtl/core/gifenc_emit.sv
rtl/core/uncompressed_gif_image_stream_encoder.sv
tb/tb.sv
